@@ hdl/ccpa_pkg.sv @@
// ----------------------------------------------------------------------------
// ccpa_pkg
// Types and constants shared by the cross-correlation power accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package ccpa_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int PROD_W      = 2 * SAMPLE_BITS;
   localparam int FULL_W      = PROD_W + SAMPLE_BITS;
   localparam int TERM_W      = PROD_W + 2;
   localparam int SUM_W       = 64;
   localparam int VAR_W       = 63;

   localparam logic [VAR_W-1:0] VAR_MAX = {VAR_W{1'b1}};
   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] y_re;
      logic signed [SAMPLE_BITS-1:0] y_im;
      logic signed [SAMPLE_BITS-1:0] u_re;
      logic signed [SAMPLE_BITS-1:0] u_im;
      logic        [SAMPLE_BITS-1:0] sigma_sq;
      logic                          last_pair;
   } req_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] cross_power;
      logic        [VAR_W-1:0] power_variance;
      logic                    saturated;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_PP_LO,
      ST_PP_HI,
      ST_MERGE,
      ST_ACC
   } state_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic sum;
      logic pp_lo;
      logic pp_hi;
      logic merge;
      logic acc;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic last_pair;
   } status_type;

endpackage

`default_nettype wire

@@ hdl/ccpa_ctrl.sv @@
// ----------------------------------------------------------------------------
// ccpa_ctrl
// Sequencer for one pair: capture, products, combine, variance product in two
// halves, merge, accumulate, and the result valid register.
// ----------------------------------------------------------------------------
`default_nettype none

module ccpa_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire ccpa_pkg::status_type status,
   output ccpa_pkg::cmd_type         cmd
);

   ccpa_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ccpa_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ccpa_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = ccpa_pkg::ST_MUL;
            end
         end
         ccpa_pkg::ST_MUL:   state_in = ccpa_pkg::ST_SUM;
         ccpa_pkg::ST_SUM:   state_in = ccpa_pkg::ST_PP_LO;
         ccpa_pkg::ST_PP_LO: state_in = ccpa_pkg::ST_PP_HI;
         ccpa_pkg::ST_PP_HI: state_in = ccpa_pkg::ST_MERGE;
         ccpa_pkg::ST_MERGE: state_in = ccpa_pkg::ST_ACC;
         ccpa_pkg::ST_ACC: begin
            if (!status.last_pair || out_free) begin
               state_in = ccpa_pkg::ST_IDLE;
            end
         end
         default: state_in = ccpa_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ccpa_pkg::ST_IDLE:  cmd.load  = req_valid;
         ccpa_pkg::ST_MUL:   cmd.mul   = 1'b1;
         ccpa_pkg::ST_SUM:   cmd.sum   = 1'b1;
         ccpa_pkg::ST_PP_LO: cmd.pp_lo = 1'b1;
         ccpa_pkg::ST_PP_HI: cmd.pp_hi = 1'b1;
         ccpa_pkg::ST_MERGE: cmd.merge = 1'b1;
         ccpa_pkg::ST_ACC: begin
            cmd.acc  = !status.last_pair || out_free;
            cmd.emit = status.last_pair && out_free;
         end
         default: cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ccpa_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_rise_after_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.emit))
      else $error("result valid rose without an emit");

   a_no_emit_over_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !cmd.emit)
      else $error("emit overwrote a held result");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ccpa_pkg::ST_MUL))
      else $error("accepted transfer did not start the sequence");
`endif

endmodule

`default_nettype wire

@@ hdl/ccpa_datapath.sv @@
// ----------------------------------------------------------------------------
// ccpa_datapath
// Pair register, product registers, shared variance multiplier, saturating
// sums and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ccpa_datapath #(
   parameter int FRAC_BITS = 23
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ccpa_pkg::req_type    req_data,
   input  wire ccpa_pkg::cmd_type    cmd,
   output ccpa_pkg::status_type      status,
   output ccpa_pkg::rsp_type         rsp_data
);

   localparam int SB = ccpa_pkg::SAMPLE_BITS;
   localparam int PW = ccpa_pkg::PROD_W;
   localparam int FW = ccpa_pkg::FULL_W;
   localparam int TW = ccpa_pkg::TERM_W;
   localparam int SW = ccpa_pkg::SUM_W;
   localparam int VW = ccpa_pkg::VAR_W;

   ccpa_pkg::req_type item_ff;
   ccpa_pkg::rsp_type rsp_ff;

   logic signed [PW-1:0] yr_ur_ff, yi_ui_ff, ur_ur_ff, ui_ui_ff;
   logic signed [PW-1:0] yr_ur_in, yi_ui_in, ur_ur_in, ui_ui_in;
   logic signed [PW-1:0] p1, p2, sq_re, sq_im;
   logic signed [PW:0]   diff;
   logic signed [TW-1:0] term_ff, term_in;
   logic        [PW-1:0] m_ff, m_in;
   logic        [SB-1:0] mul_a;
   logic        [PW-1:0] pp_in, pp_lo_ff, pp_hi_ff;
   logic        [FW-1:0] full_ff, full_in;

   logic        [FW-1:0] v_sh;
   logic                 v_clamp;
   logic        [VW-1:0] v2;
   logic        [VW:0]   vs;
   logic        [VW-1:0] var_next;
   logic                 var_ovf;
   logic signed [SW:0]   ps;
   logic signed [SW-1:0] pw_next;
   logic                 pw_ovf;
   logic                 ovf_next;

   logic signed [SW-1:0] power_sum_ff;
   logic        [VW-1:0] variance_sum_ff;
   logic                 overflow_ff;

   assign status.last_pair = item_ff.last_pair;
   assign rsp_data         = rsp_ff;

   assign yr_ur_in = item_ff.y_re * item_ff.u_re;
   assign yi_ui_in = item_ff.y_im * item_ff.u_im;
   assign ur_ur_in = item_ff.u_re * item_ff.u_re;
   assign ui_ui_in = item_ff.u_im * item_ff.u_im;

   assign p1      = yr_ur_ff >>> FRAC_BITS;
   assign p2      = yi_ui_ff >>> FRAC_BITS;
   assign diff    = {p1[PW-1], p1} - {p2[PW-1], p2};
   assign term_in = {diff, 1'b0};
   assign sq_re   = ur_ur_ff >>> FRAC_BITS;
   assign sq_im   = ui_ui_ff >>> FRAC_BITS;
   assign m_in    = $unsigned(sq_re) + $unsigned(sq_im);

   assign mul_a   = cmd.pp_hi ? m_ff[PW-1:SB] : m_ff[SB-1:0];
   assign pp_in   = mul_a * item_ff.sigma_sq;
   assign full_in = {pp_hi_ff, {SB{1'b0}}} + {{SB{1'b0}}, pp_lo_ff};

   assign v_sh     = full_ff >> FRAC_BITS;
   assign v_clamp  = (|v_sh[FW-1:VW]) || v_sh[VW-1];
   assign v2       = v_clamp ? ccpa_pkg::VAR_MAX : {v_sh[VW-2:0], 1'b0};
   assign vs       = {1'b0, variance_sum_ff} + {1'b0, v2};
   assign var_ovf  = vs[VW];
   assign var_next = var_ovf ? ccpa_pkg::VAR_MAX : vs[VW-1:0];

   assign ps       = {power_sum_ff[SW-1], power_sum_ff}
                     + {{(SW+1-TW){term_ff[TW-1]}}, term_ff};
   assign pw_ovf   = ps[SW] ^ ps[SW-1];
   assign pw_next  = pw_ovf ? (ps[SW] ? ccpa_pkg::SUM_MIN : ccpa_pkg::SUM_MAX)
                            : ps[SW-1:0];
   assign ovf_next = overflow_ff || v_clamp || var_ovf || pw_ovf;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_data;
      end
      if (cmd.mul) begin
         yr_ur_ff <= yr_ur_in;
         yi_ui_ff <= yi_ui_in;
         ur_ur_ff <= ur_ur_in;
         ui_ui_ff <= ui_ui_in;
      end
      if (cmd.sum) begin
         term_ff <= term_in;
         m_ff    <= m_in;
      end
      if (cmd.pp_lo) begin
         pp_lo_ff <= pp_in;
      end
      if (cmd.pp_hi) begin
         pp_hi_ff <= pp_in;
      end
      if (cmd.merge) begin
         full_ff <= full_in;
      end
      if (cmd.emit) begin
         rsp_ff.cross_power    <= pw_next;
         rsp_ff.power_variance <= var_next;
         rsp_ff.saturated      <= ovf_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         power_sum_ff    <= '0;
         variance_sum_ff <= '0;
         overflow_ff     <= 1'b0;
      end else if (cmd.acc) begin
         if (cmd.emit) begin
            power_sum_ff    <= '0;
            variance_sum_ff <= '0;
            overflow_ff     <= 1'b0;
         end else begin
            power_sum_ff    <= pw_next;
            variance_sum_ff <= var_next;
            overflow_ff     <= ovf_next;
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_clear_after_emit: assert property (@(posedge clock) disable iff (reset)
      (cmd.acc && cmd.emit) |=>
         (power_sum_ff == '0) && (variance_sum_ff == '0) && !overflow_ff)
      else $error("sums not cleared after a set");

   a_sums_hold: assert property (@(posedge clock) disable iff (reset)
      !$past(cmd.acc) && !$past(reset) |->
         $stable(power_sum_ff) && $stable(variance_sum_ff))
      else $error("sums changed outside the accumulate step");
`endif

endmodule

`default_nettype wire

@@ hdl/cross_corr_power_accumulator_core.sv @@
// ----------------------------------------------------------------------------
// cross_corr_power_accumulator_core
// Weighted complex dot product with variance, accumulated over a set of pairs.
// ----------------------------------------------------------------------------
// Each pair runs through these steps before the next transfer can be taken:
// capture, the four 24x24 products, combining them, the variance product (a
// 48-bit sum of squares times sigma_sq, formed in two halves on one shared
// 24x24 multiplier), merging the halves, then saturating and accumulating.
// A pair marked last waits in the accumulate step
// while a previous result is still held by rsp_stall; otherwise results sit in
// an output register and the next pair is taken meanwhile. Power and variance
// sums saturate (signed 64-bit and 2^63-1) and any clamp sets the saturated
// flag; both sums clear once the result of a set is loaded. No clearing pass
// after reset.
`default_nettype none

module cross_corr_power_accumulator_core #(
   parameter int FRAC_BITS = 23
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire ccpa_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output ccpa_pkg::rsp_type      rsp_data
);

   ccpa_pkg::cmd_type    cmd;
   ccpa_pkg::status_type status;

   ccpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ccpa_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

@@ test/cross_corr_power_accumulator_checker.sv @@
// ----------------------------------------------------------------------------
// cross_corr_power_accumulator_checker
// Watches both channels of the power accumulator, predicts the power and
// variance sums of every set of pairs and compares each result transfer
// against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module cross_corr_power_accumulator_checker
   import ccpa_pkg::*;
#(
   parameter int FRAC_BITS = 23
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_stall,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_stall,
   input  wire rsp_type rsp_data,
   output int           results_due,
   output int           error_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [127:0] wide_type;

   logic signed [SUM_W-1:0] power_acc;
   logic        [VAR_W-1:0] variance_acc;
   logic                    clamp_seen;
   rsp_type                 set_results_q[$];

   function automatic wide_type sat_power(input wide_type x);
      wide_type hi, lo;
      hi = wide_type'(SUM_MAX);
      lo = wide_type'(SUM_MIN);
      if (x > hi) begin
         clamp_seen = 1'b1;
         return hi;
      end
      if (x < lo) begin
         clamp_seen = 1'b1;
         return lo;
      end
      return x;
   endfunction

   function automatic wide_type sat_variance(input wide_type x);
      wide_type hi;
      hi = {65'd0, VAR_MAX};
      if (x > hi) begin
         clamp_seen = 1'b1;
         return hi;
      end
      return x;
   endfunction

   function automatic void accumulate_pair(input req_type pair);
      wide_type yr, yi, ur, ui, sq, term, mag, var_term, acc;
      yr = wide_type'(pair.y_re);
      yi = wide_type'(pair.y_im);
      ur = wide_type'(pair.u_re);
      ui = wide_type'(pair.u_im);
      sq = {104'd0, pair.sigma_sq};
      term = sat_power(((yr * ur) >>> FRAC_BITS) - ((yi * ui) >>> FRAC_BITS));
      term = sat_power(term + term);
      acc = wide_type'(power_acc);
      power_acc = SUM_W'(sat_power(acc + term));
      mag = sat_variance(((ur * ur) >>> FRAC_BITS) + ((ui * ui) >>> FRAC_BITS));
      var_term = sat_variance((mag * sq) >>> FRAC_BITS);
      var_term = sat_variance(var_term + var_term);
      acc = {65'd0, variance_acc};
      variance_acc = VAR_W'(sat_variance(acc + var_term));
      if (pair.last_pair) begin
         set_results_q.push_back('{power_acc, variance_acc, clamp_seen});
         power_acc = '0;
         variance_acc = '0;
         clamp_seen = 1'b0;
      end
   endfunction

   function automatic void flag_mismatch(input string what, input logic [63:0] want,
                                         input logic [63:0] got);
      if (error_count < 10)
         $display("ERROR at %0t: %s expected %h got %h", $time, what, want, got);
      error_count++;
   endfunction

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         power_acc = '0;
         variance_acc = '0;
         clamp_seen = 1'b0;
         error_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (set_results_q.size() == 0) begin
               flag_mismatch("unexpected result, cross_power", '0, rsp_data.cross_power);
            end else begin
               want = set_results_q.pop_front();
               if (rsp_data.cross_power !== want.cross_power)
                  flag_mismatch("cross_power", want.cross_power, rsp_data.cross_power);
               if (rsp_data.power_variance !== want.power_variance)
                  flag_mismatch("power_variance", 64'(want.power_variance),
                                64'(rsp_data.power_variance));
               if (rsp_data.saturated !== want.saturated)
                  flag_mismatch("saturated", 64'(want.saturated), 64'(rsp_data.saturated));
            end
         end
         if (req_valid && !req_stall)
            accumulate_pair(req_data);
      end
      results_due <= set_results_q.size();
   end

endmodule

`default_nettype wire

@@ test/cross_corr_power_accumulator_core_test.sv @@
// ----------------------------------------------------------------------------
// cross_corr_power_accumulator_core_test
// Drives sets of correlation pairs into the power accumulator: a directed
// run over field extremes and rounding corners, then random sets with
// random gaps and result stalls. A checker beside the block predicts and
// compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module cross_corr_power_accumulator_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import ccpa_pkg::*;

   localparam int CLOCK_PERIOD = 20;
   localparam int FRAC_BITS    = 23;
   localparam int RANDOM_PAIRS = 1330;
   localparam int QUIET_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 20;

   localparam logic [SAMPLE_BITS-1:0] S_MAX  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] S_MIN  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic [SAMPLE_BITS-1:0] S_ONE  = SAMPLE_BITS'(1);
   localparam logic [SAMPLE_BITS-1:0] S_NEG1 = '1;
   localparam logic [SAMPLE_BITS-1:0] U_MAX  = '1;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    rsp_stall = 1'b0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      results_due;
   int      error_count;
   bit      steady    = 1'b0;
   int      pairs_sent = 0;
   int      stall_left = 0;

   cross_corr_power_accumulator_core #(
      .FRAC_BITS(FRAC_BITS)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   cross_corr_power_accumulator_checker #(
      .FRAC_BITS(FRAC_BITS)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .results_due(results_due),
      .error_count(error_count)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (!steady && $urandom_range(99) < 2) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(4);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(15))
         0: return S_MAX;
         1: return S_MIN;
         2: return '0;
         3: return S_NEG1;
         4: return S_ONE;
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   function automatic req_type make_pair(input logic [SAMPLE_BITS-1:0] yr, yi, ur, ui, sq,
                                         input logic last);
      req_type p;
      p.y_re = yr;
      p.y_im = yi;
      p.u_re = ur;
      p.u_im = ui;
      p.sigma_sq = sq;
      p.last_pair = last;
      return p;
   endfunction

   function automatic req_type random_pair(input logic last);
      return make_pair(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                       pick_sample(), last);
   endfunction

   task automatic send_pair(input req_type p);
      int gap;
      steady = (pairs_sent >= 500) && (pairs_sent < 800);
      if (!steady && $urandom_range(99) < 12) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pairs_sent++;
   endtask

   initial begin : stimulus
      int set_len, random_sent;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_pair(make_pair('0, '0, '0, '0, '0, 1'b1));
      send_pair(make_pair(S_MAX, S_MAX, S_MAX, S_MAX, U_MAX, 1'b1));
      send_pair(make_pair(S_MIN, S_MIN, S_MIN, S_MIN, U_MAX, 1'b1));
      send_pair(make_pair(S_MIN, S_MAX, S_MAX, S_MIN, U_MAX, 1'b0));
      send_pair(make_pair(S_MAX, S_MIN, S_MIN, S_MAX, S_ONE, 1'b0));
      send_pair(make_pair(S_NEG1, S_ONE, S_ONE, S_NEG1, S_ONE, 1'b1));
      send_pair(make_pair(S_NEG1, S_NEG1, S_ONE, S_ONE, '0, 1'b1));
      send_pair(make_pair(S_ONE, '0, S_ONE, '0, U_MAX, 1'b1));
      repeat (3) send_pair(make_pair(S_MIN, S_MAX, S_MIN, S_MIN, U_MAX, 1'b0));
      send_pair(make_pair(S_MIN, S_MAX, S_MIN, S_MIN, U_MAX, 1'b1));
      send_pair(make_pair('0, '0, S_MIN, S_MIN, U_MAX, 1'b1));
      send_pair(make_pair(S_MAX, S_MIN, S_NEG1, S_MIN, S_MAX, 1'b0));
      send_pair(make_pair(S_MIN, S_NEG1, S_MAX, S_ONE, S_MIN, 1'b1));
      repeat (4) send_pair(random_pair(1'b1));

      random_sent = 0;
      while (random_sent < RANDOM_PAIRS) begin
         set_len = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
         for (int i = 1; i <= set_len; i++)
            send_pair(random_pair(i == set_len));
         random_sent += set_len;
      end

      req_valid <= 1'b0;
      steady = 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire
